// ===== hw/rtl/alc_pkg.sv =====
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants for the light culling block
// Request codes, result kinds, sequencer states and the light record that
// feeds the overlap unit.
// ----------------------------------------------------------------------------
package alc_pkg;

    localparam int unsigned BOX_SLOTS_DEF       = 16;
    localparam int unsigned POINT_SLOTS_DEF     = 16;
    localparam int unsigned BOX_HIT_LIMIT_DEF   = 8;
    localparam int unsigned POINT_HIT_LIMIT_DEF = 8;

    localparam int unsigned COORD_W  = 16;   // Q12.4 coordinate
    localparam int unsigned VEC_W    = 3 * COORD_W;
    localparam int unsigned RADIUS_W = 15;
    localparam int unsigned WIDE_W   = COORD_W + 2;  // centre +/- radius never wraps
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned HIDX_W   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_BOX   = 2'd0,
        FUNC_WR_POINT = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_NOP      = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_BOX   = 2'd0,
        KIND_POINT = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BOX,
        S_POINT,
        S_FLUSH
    } t_state;

    // One stored light as presented to the overlap unit. For a point light
    // lo carries the centre and hi is unused.
    typedef struct packed {
        logic                is_point;
        logic [VEC_W-1:0]    lo;
        logic [VEC_W-1:0]    hi;
        logic [RADIUS_W-1:0] radius;
    } t_light;

endpackage

// ===== hw/rtl/alc_overlap.sv =====
// ----------------------------------------------------------------------------
// alc_overlap: inclusive AABB overlap test, one light per cycle
// Builds the light's bounds (box corners, or centre +/- radius for a point
// light) 18 bits wide and compares them against the query box on each axis.
// ----------------------------------------------------------------------------
module alc_overlap import alc_pkg::*; (
    input  logic [VEC_W-1:0] i_q_lo,
    input  logic [VEC_W-1:0] i_q_hi,
    input  t_light           i_light,
    output logic             o_hit
);

    logic [2:0] ax_ok;

    always_comb begin
        logic signed [WIDE_W-1:0] q_lo;
        logic signed [WIDE_W-1:0] q_hi;
        logic signed [WIDE_W-1:0] l_lo;
        logic signed [WIDE_W-1:0] l_hi;
        logic signed [WIDE_W-1:0] rad;
        for (int a = 0; a < 3; a++) begin
            q_lo = WIDE_W'($signed(i_q_lo[a*COORD_W +: COORD_W]));
            q_hi = WIDE_W'($signed(i_q_hi[a*COORD_W +: COORD_W]));
            rad  = $signed({{(WIDE_W-RADIUS_W){1'b0}}, i_light.radius});
            if (i_light.is_point) begin
                l_lo = WIDE_W'($signed(i_light.lo[a*COORD_W +: COORD_W])) - rad;
                l_hi = WIDE_W'($signed(i_light.lo[a*COORD_W +: COORD_W])) + rad;
            end else begin
                l_lo = WIDE_W'($signed(i_light.lo[a*COORD_W +: COORD_W]));
                l_hi = WIDE_W'($signed(i_light.hi[a*COORD_W +: COORD_W]));
            end
            ax_ok[a] = !((q_hi < l_lo) || (q_lo > l_hi));
        end
    end

    assign o_hit = &ax_ok;

endmodule

// ===== hw/rtl/aabb_light_culling.sv =====
// ----------------------------------------------------------------------------
// aabb_light_culling: box and point light tables with bounding-box culling
// Write requests fill or clear a slot; a query request walks both tables
// through one shared overlap unit and emits the hit list.
// ----------------------------------------------------------------------------
// Write requests return no result. A query walks the box table and then
// the point table, one slot per cycle through the overlap unit behind one
// memory read stage per table, and ends in a flush state. A table scan
// stops early once its hit limit is reached. Output stalls hold the scan.
// Reset (synchronous, active low) clears valid bits and control; the
// light data stores are not cleared, since only valid slots can hit.
module aabb_light_culling import alc_pkg::*; #(
    parameter int unsigned BOX_SLOTS       = BOX_SLOTS_DEF,
    parameter int unsigned POINT_SLOTS     = POINT_SLOTS_DEF,
    parameter int unsigned BOX_HIT_LIMIT   = BOX_HIT_LIMIT_DEF,
    parameter int unsigned POINT_HIT_LIMIT = POINT_HIT_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_enable,
    input  logic [COORD_W-1:0]  i_low_x,
    input  logic [COORD_W-1:0]  i_low_y,
    input  logic [COORD_W-1:0]  i_low_z,
    input  logic [COORD_W-1:0]  i_high_x,
    input  logic [COORD_W-1:0]  i_high_y,
    input  logic [COORD_W-1:0]  i_high_z,
    input  logic [RADIUS_W-1:0] i_reach,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KIND_W-1:0]   o_kind,
    output logic [SLOT_W-1:0]   o_light_slot,
    output logic [HIDX_W-1:0]   o_hit_index,
    output logic                o_last
);

    localparam int unsigned BOX_AW   = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
    localparam int unsigned POINT_AW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
    localparam int unsigned MAX_SLOTS =
        (BOX_SLOTS > POINT_SLOTS) ? BOX_SLOTS : POINT_SLOTS;
    // scan counter must hold the slot count itself (past-the-end)
    localparam int unsigned SCAN_W = $clog2(MAX_SLOTS + 1);
    localparam int unsigned MAX_LIMIT =
        (BOX_HIT_LIMIT > POINT_HIT_LIMIT) ? BOX_HIT_LIMIT : POINT_HIT_LIMIT;
    localparam int unsigned CNT_W = $clog2(MAX_LIMIT + 1);

    // ------------------------------------------------------------------
    // Light stores: valid bits in flops, data in memories
    // ------------------------------------------------------------------
    logic [BOX_SLOTS-1:0]   r_box_vld;
    logic [POINT_SLOTS-1:0] r_pt_vld;
    logic [VEC_W-1:0]       box_lo_mem [BOX_SLOTS];
    logic [VEC_W-1:0]       box_hi_mem [BOX_SLOTS];
    logic [VEC_W-1:0]       pt_c_mem   [POINT_SLOTS];
    logic [RADIUS_W-1:0]    pt_r_mem   [POINT_SLOTS];

    // ------------------------------------------------------------------
    // Sequencer and scan state
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [SCAN_W-1:0]   r_addr;       // next slot to read
    logic                r_s1_act;     // a slot sits in the read stage
    logic                r_s1_lv;      // ... and its light is valid
    logic                r_s1_end;     // ... and it is the table's last slot
    logic [SCAN_W-1:0]   r_s1_slot;
    logic [VEC_W-1:0]    r_rd_lo;
    logic [VEC_W-1:0]    r_rd_hi;
    logic [RADIUS_W-1:0] r_rd_rad;
    logic [CNT_W-1:0]    r_cnt;        // hits so far in this table

    logic [VEC_W-1:0]    r_q_lo;
    logic [VEC_W-1:0]    r_q_hi;

    // one hit held back so the final one can carry last
    logic                r_pend_vld;
    logic [KIND_W-1:0]   r_pend_kind;
    logic [SLOT_W-1:0]   r_pend_slot;
    logic [HIDX_W-1:0]   r_pend_idx;

    logic                r_out_vld;
    logic [KIND_W-1:0]   r_out_kind;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [HIDX_W-1:0]   r_out_idx;
    logic                r_out_last;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic  in_acc;
    logic  wr_box, wr_pt, start_q;
    t_func func;

    assign func       = t_func'(i_func);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        wr_box  = 1'b0;
        wr_pt   = 1'b0;
        start_q = 1'b0;
        unique case (func)
            FUNC_WR_BOX:   wr_box  = in_acc && (32'(i_slot) < BOX_SLOTS);
            FUNC_WR_POINT: wr_pt   = in_acc && (32'(i_slot) < POINT_SLOTS);
            FUNC_QUERY:    start_q = in_acc;
            default:       ;   // unused code, request dropped
        endcase
    end

    // ------------------------------------------------------------------
    // Shared overlap unit
    // ------------------------------------------------------------------
    t_light s1_light;
    logic   ovl_hit;

    assign s1_light = '{is_point: (r_state == S_POINT), lo: r_rd_lo,
                        hi: r_rd_hi, radius: r_rd_rad};

    alc_overlap u_overlap (
        .i_q_lo  (r_q_lo),
        .i_q_hi  (r_q_hi),
        .i_light (s1_light),
        .o_hit   (ovl_hit)
    );

    // ------------------------------------------------------------------
    // Sequencer control (outputs)
    // ------------------------------------------------------------------
    logic              scanning;
    logic              issue;
    logic              slot_vld;
    logic              found;
    logic              out_free;
    logic              advance;
    logic              phase_done;
    logic              push;
    logic              push_pend;
    logic [CNT_W-1:0]  lim;
    logic [SCAN_W-1:0] end_addr;
    logic [KIND_W-1:0] cur_kind;

    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        scanning   = 1'b0;
        issue      = 1'b0;
        slot_vld   = 1'b0;
        lim        = CNT_W'(BOX_HIT_LIMIT);
        end_addr   = SCAN_W'(BOX_SLOTS - 1);
        cur_kind   = KIND_BOX;
        push       = 1'b0;
        push_pend  = 1'b0;
        unique case (r_state)
            S_BOX: begin
                scanning = 1'b1;
                issue    = (32'(r_addr) < BOX_SLOTS);
                slot_vld = issue && r_box_vld[r_addr[BOX_AW-1:0]];
            end
            S_POINT: begin
                scanning = 1'b1;
                issue    = (32'(r_addr) < POINT_SLOTS);
                slot_vld = issue && r_pt_vld[r_addr[POINT_AW-1:0]];
                lim      = CNT_W'(POINT_HIT_LIMIT);
                end_addr = SCAN_W'(POINT_SLOTS - 1);
                cur_kind = KIND_POINT;
            end
            S_FLUSH: begin
                push = out_free;
            end
            default: ;
        endcase

        found = scanning && r_s1_act && r_s1_lv && ovl_hit && (r_cnt < lim);
        // a new hit displaces the held one, which needs a free output
        advance    = !(found && r_pend_vld && !out_free);
        phase_done = scanning && advance && r_s1_act &&
                     (r_s1_end || (found && (r_cnt == lim - CNT_W'(1))));
        if (found && r_pend_vld && advance) begin
            push      = 1'b1;
            push_pend = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start_q) n_state = S_BOX;
            S_BOX:   if (phase_done) n_state = S_POINT;
            S_POINT: if (phase_done) n_state = S_FLUSH;
            S_FLUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Store writes and scan reads
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_vld <= '0;
            r_pt_vld  <= '0;
        end else begin
            if (wr_box) r_box_vld[BOX_AW'(i_slot)] <= i_enable;
            if (wr_pt)  r_pt_vld[POINT_AW'(i_slot)] <= i_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_box && i_enable) begin
            box_lo_mem[BOX_AW'(i_slot)] <= {i_low_z, i_low_y, i_low_x};
            box_hi_mem[BOX_AW'(i_slot)] <= {i_high_z, i_high_y, i_high_x};
        end
        if (wr_pt && i_enable) begin
            pt_c_mem[POINT_AW'(i_slot)] <= {i_low_z, i_low_y, i_low_x};
            pt_r_mem[POINT_AW'(i_slot)] <= i_reach;
        end
    end

    // registered read port, held while the scan is stalled
    always_ff @(posedge i_clk) begin
        if (issue && advance) begin
            if (r_state == S_POINT) begin
                r_rd_lo  <= pt_c_mem[r_addr[POINT_AW-1:0]];
                r_rd_rad <= pt_r_mem[r_addr[POINT_AW-1:0]];
            end else begin
                r_rd_lo  <= box_lo_mem[r_addr[BOX_AW-1:0]];
                r_rd_hi  <= box_hi_mem[r_addr[BOX_AW-1:0]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan pointer, read stage tags, hit counter, query box
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_s1_act <= 1'b0;
            r_s1_lv  <= 1'b0;
            r_s1_end <= 1'b0;
            r_cnt    <= '0;
        end else if (!scanning || phase_done) begin
            r_addr   <= '0;
            r_s1_act <= 1'b0;
            r_s1_lv  <= 1'b0;
            r_s1_end <= 1'b0;
            r_cnt    <= '0;
        end else if (advance) begin
            r_s1_act <= issue;
            r_s1_lv  <= slot_vld;
            r_s1_end <= issue && (r_addr == end_addr);
            if (issue) r_addr <= r_addr + SCAN_W'(1);
            if (found) r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (scanning && advance && issue) r_s1_slot <= r_addr;
        if (start_q) begin
            r_q_lo <= {i_low_z, i_low_y, i_low_x};
            r_q_hi <= {i_high_z, i_high_y, i_high_x};
        end
    end

    // ------------------------------------------------------------------
    // Held hit and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (found && advance) begin
            r_pend_vld <= 1'b1;
        end else if (r_state == S_FLUSH && push) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (found && advance) begin
            r_pend_kind <= cur_kind;
            r_pend_slot <= SLOT_W'(r_s1_slot);
            r_pend_idx  <= HIDX_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (push_pend || r_pend_vld) begin
                r_out_kind <= r_pend_kind;
                r_out_slot <= r_pend_slot;
                r_out_idx  <= r_pend_idx;
            end else begin
                // empty hit list: single "none" result
                r_out_kind <= KIND_NONE;
                r_out_slot <= '0;
                r_out_idx  <= '0;
            end
            r_out_last <= !push_pend;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_kind       = r_out_kind;
    assign o_light_slot = r_out_slot;
    assign o_hit_index  = r_out_idx;
    assign o_last       = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("held hit left over after a query");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scanning |-> (r_cnt < lim))
        else $error("hit count passed its limit");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free) |=> (r_state == S_IDLE && r_out_vld && r_out_last))
        else $error("flush did not end the query with a last result");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_kind == KIND_NONE) |-> r_out_last)
        else $error("none result without last");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed over a stalled output");

endmodule

// ===== verif/light_hit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_hit_checker: result predictor and scoreboard for aabb_light_culling
// Watches both channels, keeps its own copy of the light tables, predicts the
// hit list of each accepted query and compares every accepted result in order.
// ----------------------------------------------------------------------------
module light_hit_checker import alc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_enable,
    input  logic [COORD_W-1:0]  i_low_x,
    input  logic [COORD_W-1:0]  i_low_y,
    input  logic [COORD_W-1:0]  i_low_z,
    input  logic [COORD_W-1:0]  i_high_x,
    input  logic [COORD_W-1:0]  i_high_y,
    input  logic [COORD_W-1:0]  i_high_z,
    input  logic [RADIUS_W-1:0] i_reach,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_light_slot,
    input  logic [HIDX_W-1:0]   i_hit_index,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [HIDX_W-1:0]   hidx;
        logic                last;
    } t_hit;

    // shadow light tables, vectors packed as {z, y, x}
    logic                box_on    [BOX_SLOTS_DEF]   = '{default: 1'b0};
    logic [VEC_W-1:0]    box_lo    [BOX_SLOTS_DEF]   = '{default: '0};
    logic [VEC_W-1:0]    box_hi    [BOX_SLOTS_DEF]   = '{default: '0};
    logic                point_on  [POINT_SLOTS_DEF] = '{default: 1'b0};
    logic [VEC_W-1:0]    point_ctr [POINT_SLOTS_DEF] = '{default: '0};
    logic [RADIUS_W-1:0] point_rad [POINT_SLOTS_DEF] = '{default: '0};

    t_hit hits_due[$];
    int   fail_count    = 0;
    int   pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR light result: %s", msg);
        fail_count++;
    endtask

    function automatic logic signed [WIDE_W-1:0] coord_of(input logic [VEC_W-1:0] v,
                                                          input int a);
        return WIDE_W'($signed(v[a*COORD_W +: COORD_W]));
    endfunction

    // inclusive interval test on one axis
    function automatic bit axis_overlap(input logic signed [WIDE_W-1:0] qlo,
                                        input logic signed [WIDE_W-1:0] qhi,
                                        input logic signed [WIDE_W-1:0] llo,
                                        input logic signed [WIDE_W-1:0] lhi);
        return !(qhi < llo || qlo > lhi);
    endfunction

    task automatic predict_hits(input logic [VEC_W-1:0] qlo, input logic [VEC_W-1:0] qhi);
        int                        found;
        int                        count;
        int                        tail;
        bit                        hit;
        logic signed [WIDE_W-1:0]  c;
        logic signed [WIDE_W-1:0]  r;
        found = 0;
        count = 0;
        for (int i = 0; i < BOX_SLOTS_DEF && count < BOX_HIT_LIMIT_DEF; i++) begin
            if (box_on[i]) begin
                hit = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    if (!axis_overlap(coord_of(qlo, a), coord_of(qhi, a),
                                      coord_of(box_lo[i], a), coord_of(box_hi[i], a)))
                        hit = 1'b0;
                end
                if (hit) begin
                    hits_due.push_back('{KIND_BOX, SLOT_W'(i), HIDX_W'(count), 1'b0});
                    count++;
                    found++;
                end
            end
        end
        count = 0;
        for (int i = 0; i < POINT_SLOTS_DEF && count < POINT_HIT_LIMIT_DEF; i++) begin
            if (point_on[i]) begin
                hit = 1'b1;
                r   = WIDE_W'({1'b0, point_rad[i]});
                for (int a = 0; a < 3; a++) begin
                    c = coord_of(point_ctr[i], a);
                    if (!axis_overlap(coord_of(qlo, a), coord_of(qhi, a), c - r, c + r))
                        hit = 1'b0;
                end
                if (hit) begin
                    hits_due.push_back('{KIND_POINT, SLOT_W'(i), HIDX_W'(count), 1'b0});
                    count++;
                    found++;
                end
            end
        end
        if (found == 0)
            hits_due.push_back('{KIND_NONE, '0, '0, 1'b0});
        tail = hits_due.size() - 1;
        hits_due[tail].last = 1'b1;
    endtask

    task automatic apply_request();
        case (t_func'(i_func))
            FUNC_WR_BOX: begin
                if (int'(i_slot) < BOX_SLOTS_DEF) begin
                    box_on[i_slot] = i_enable;
                    if (i_enable) begin
                        box_lo[i_slot] = {i_low_z, i_low_y, i_low_x};
                        box_hi[i_slot] = {i_high_z, i_high_y, i_high_x};
                    end
                end
            end
            FUNC_WR_POINT: begin
                if (int'(i_slot) < POINT_SLOTS_DEF) begin
                    point_on[i_slot] = i_enable;
                    if (i_enable) begin
                        point_ctr[i_slot] = {i_low_z, i_low_y, i_low_x};
                        point_rad[i_slot] = i_reach;
                    end
                end
            end
            FUNC_QUERY:
                predict_hits({i_low_z, i_low_y, i_low_x}, {i_high_z, i_high_y, i_high_x});
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_hit want;
        if (hits_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                      i_kind, i_light_slot));
        end else begin
            want = hits_due.pop_front();
            if (i_kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", i_kind, want.kind));
            if (i_light_slot !== want.slot)
                report_mismatch($sformatf("slot %0d, want %0d", i_light_slot, want.slot));
            if (i_hit_index !== want.hidx)
                report_mismatch($sformatf("hit index %0d, want %0d", i_hit_index, want.hidx));
            if (i_last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", i_last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_on   = '{default: 1'b0};
            point_on = '{default: 1'b0};
            hits_due.delete();
        end else begin
            // a result can never belong to a query accepted at the same edge
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                apply_request();
        end
        pending_count = hits_due.size();
    end

endmodule

// ===== verif/tb_aabb_light_culling.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_light_culling: stimulus and verdict for the light culling block
// Directed light writes and queries at the coordinate extremes, then random
// writes and queries under several idle/stall mixes, with one long output
// hold-off. Checking is done by light_hit_checker beside the block.
// ----------------------------------------------------------------------------
module tb_aabb_light_culling;
    import alc_pkg::*;

    localparam int LIMIT_CYCLES = 500_000;
    localparam int DRAIN_CYCLES = 40;      // one full query scan plus margin
    localparam int HOLD_CYCLES  = 300;     // long output hold-off
    localparam int PHASE_ITEMS  = 26;      // about 105 random requests in 4 phases

    // whole coordinate space, used by directed requests
    localparam int C_MIN = -32768;
    localparam int C_MAX = 32767;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   in_func    = '0;
    logic [SLOT_W-1:0]   in_slot    = '0;
    logic                in_enable  = 1'b0;
    logic [COORD_W-1:0]  in_low_x   = '0;
    logic [COORD_W-1:0]  in_low_y   = '0;
    logic [COORD_W-1:0]  in_low_z   = '0;
    logic [COORD_W-1:0]  in_high_x  = '0;
    logic [COORD_W-1:0]  in_high_y  = '0;
    logic [COORD_W-1:0]  in_high_z  = '0;
    logic [RADIUS_W-1:0] in_reach   = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [KIND_W-1:0]   out_kind;
    logic [SLOT_W-1:0]   out_light_slot;
    logic [HIDX_W-1:0]   out_hit_index;
    logic                out_last;

    int fail_count;
    int pending;
    int idle_pct   = 0;   // sender idle chance, percent per cycle
    int stall_pct  = 0;   // receiver stall chance, percent per cycle
    bit hold_phase = 1'b0;
    int cycles     = 0;

    always #2 clk = ~clk;

    aabb_light_culling dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (in_func),
        .i_slot       (in_slot),
        .i_enable     (in_enable),
        .i_low_x      (in_low_x),
        .i_low_y      (in_low_y),
        .i_low_z      (in_low_z),
        .i_high_x     (in_high_x),
        .i_high_y     (in_high_y),
        .i_high_z     (in_high_z),
        .i_reach      (in_reach),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_kind       (out_kind),
        .o_light_slot (out_light_slot),
        .o_hit_index  (out_hit_index),
        .o_last       (out_last)
    );

    light_hit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_func       (in_func),
        .i_slot       (in_slot),
        .i_enable     (in_enable),
        .i_low_x      (in_low_x),
        .i_low_y      (in_low_y),
        .i_low_z      (in_low_z),
        .i_high_x     (in_high_x),
        .i_high_y     (in_high_y),
        .i_high_z     (in_high_z),
        .i_reach      (in_reach),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_kind       (out_kind),
        .i_light_slot (out_light_slot),
        .i_hit_index  (out_hit_index),
        .i_last       (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver. A rising hold_phase starts one long hold-off, counted here;
    // otherwise the stall is drawn each cycle at the phase's rate.
    int hold_left  = 0;
    bit hold_armed = 1'b0;

    always @(negedge clk) begin
        if (hold_phase && !hold_armed)
            hold_left = HOLD_CYCLES;
        hold_armed = hold_phase;
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Run limit, reckoned well above the slowest legal run.
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("aabb_light_culling: mismatch");
        $finish;
    end

    // One request: optional idle gap, then hold the payload until accepted.
    // Entered and left at a falling edge.
    task automatic send(input t_func f, input int s, input bit e,
                        input int lx, input int ly, input int lz,
                        input int hx, input int hy, input int hz, input int r);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_func   = f;
        in_slot   = SLOT_W'(s);
        in_enable = e;
        in_low_x  = COORD_W'(lx);
        in_low_y  = COORD_W'(ly);
        in_low_z  = COORD_W'(lz);
        in_high_x = COORD_W'(hx);
        in_high_y = COORD_W'(hy);
        in_high_z = COORD_W'(hz);
        in_reach  = RADIUS_W'(r);
        in_valid  = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic query_everything();
        send(FUNC_QUERY, 0, 1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0);
    endtask

    // values around the origin, so random lights and queries meet often
    function automatic int near_origin();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // 0: nearly the whole space, 1: raw 16-bit ends, else a clustered span
    function automatic int roll_mode(input int huge_pct, input int raw_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < huge_pct)
            return 0;
        if (pick < huge_pct + raw_pct)
            return 1;
        return 2;
    endfunction

    task automatic roll_extent(input int mode, input int spread,
                               output int lo, output int hi);
        int c;
        int h;
        case (mode)
            0: begin
                lo = C_MIN + int'($urandom_range(0, 255));
                hi = C_MAX - int'($urandom_range(0, 255));
            end
            1: begin
                lo = int'($urandom);
                hi = int'($urandom);
            end
            default: begin
                c  = near_origin();
                h  = $urandom_range(0, spread);
                lo = c - h;
                hi = c + h;
                // now and then an inverted span
                if ($urandom_range(0, 99) < 4) begin
                    lo = c + h + 1;
                    hi = c - h;
                end
            end
        endcase
    endtask

    task automatic roll_box_write();
        int lo[3];
        int hi[3];
        int mode;
        mode = roll_mode(15, 20);
        for (int a = 0; a < 3; a++)
            roll_extent(mode, 1500, lo[a], hi[a]);
        send(FUNC_WR_BOX, $urandom_range(0, 15), $urandom_range(0, 99) < 85,
             lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom);
    endtask

    task automatic roll_point_write();
        int ctr[3];
        int r;
        int pick;
        for (int a = 0; a < 3; a++)
            ctr[a] = ($urandom_range(0, 99) < 30) ? int'($urandom) : near_origin();
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r = $urandom_range(0, 2000);
        else if (pick < 85)
            r = $urandom;
        else
            r = 0;
        send(FUNC_WR_POINT, $urandom_range(0, 15), $urandom_range(0, 99) < 85,
             ctr[0], ctr[1], ctr[2], $urandom, $urandom, $urandom, r);
    endtask

    task automatic roll_query();
        int lo[3];
        int hi[3];
        int mode;
        mode = roll_mode(8, 15);
        for (int a = 0; a < 3; a++)
            roll_extent(mode, 3000, lo[a], hi[a]);
        send(FUNC_QUERY, $urandom_range(0, 15), $urandom_range(0, 1),
             lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom);
    endtask

    initial begin
        int sent;
        int pick;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // empty tables: a single none result
        query_everything();
        // box covering the whole space, and a box inverted on x
        send(FUNC_WR_BOX, 0, 1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX);
        send(FUNC_WR_BOX, 15, 1'b1, 100, 0, 0, -100, 50, 50, 0);
        // point at the top corner with maximum radius (needs the wide sum),
        // and a zero-radius point at the bottom corner
        send(FUNC_WR_POINT, 0, 1'b1, C_MAX, C_MAX, C_MAX, 0, 0, 0, 32767);
        send(FUNC_WR_POINT, 15, 1'b1, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0);
        query_everything();
        // query box inverted on y: only the whole-space box still hits
        send(FUNC_QUERY, 0, 1'b0, 0, 10, 0, 0, -10, 0, 0);
        // degenerate queries touching the zero-radius point and the edge of
        // the big point's reach, inclusive
        send(FUNC_QUERY, 0, 1'b0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0);
        send(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        // unknown function code with every field set: ignored
        send(FUNC_NOP, 15, 1'b1, -1, -1, -1, -1, -1, -1, 32767);
        // destroy the whole-space box; its data stays but must not be used
        send(FUNC_WR_BOX, 0, 1'b0, 1, 1, 1, 2, 2, 2, 5);
        query_everything();
        // nine more whole-space boxes: the box list stops at its hit limit
        for (int s = 1; s <= 9; s++)
            send(FUNC_WR_BOX, s, 1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0);
        query_everything();
        send(FUNC_WR_POINT, 0, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        query_everything();

        // ---- random part, one idle/stall mix per phase ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 0 && sent == 8) begin
                    // output held off while queries keep coming: the block
                    // fills up and has to stall its request side
                    hold_phase = 1'b1;
                    repeat (3) query_everything();
                    hold_phase = 1'b0;
                    sent += 3;
                end
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    roll_box_write();
                    sent++;
                end else if (pick < 55) begin
                    roll_point_write();
                    sent++;
                end else if (pick < 95) begin
                    roll_query();
                    sent++;
                end else begin
                    send(FUNC_NOP, $urandom_range(0, 15), $urandom_range(0, 1),
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                end
            end
        end
        in_valid = 1'b0;

        // drain: every predicted result must arrive, then a quiet stretch
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("aabb_light_culling: match");
        else
            $display("aabb_light_culling: mismatch");
        $finish;
    end

endmodule
